// File: rtl/core/lvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeled voxel centroid grid package
// Shared constants, register indexes and structures of the centroid grid.
// ----------------------------------------------------------------------------
package lvc_pkg;

	localparam int unsigned POLARITIES = 2;
	localparam int unsigned DEF_TABLE_SLOTS = 1024;
	localparam int unsigned DEF_PROBE_LIMIT = 8;

	localparam int unsigned SUM_W = 56;
	localparam int unsigned CNT_W = 24;
	localparam int unsigned DIVS_W = 24;
	localparam int unsigned DROP_W = 16;
	localparam int unsigned PADDR_W = 6;

	localparam logic [2:0] REG_ROT_ROW_X = 3'd0;
	localparam logic [2:0] REG_ROT_ROW_Y = 3'd1;
	localparam logic [2:0] REG_TRANS_X = 3'd2;
	localparam logic [2:0] REG_TRANS_Y = 3'd3;
	localparam logic [2:0] REG_INV_VOXEL = 3'd4;

	localparam logic [47:0] ROT_X_RESET = 48'd16384;
	localparam logic [47:0] ROT_Y_RESET = 48'd1073741824;
	localparam logic [31:0] INV_VOXEL_RESET = 32'd65536;

	localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
	localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

	localparam logic [7:0] LABEL_ROAD_A = 8'd1;
	localparam logic [7:0] LABEL_ROAD_B = 8'd5;
	localparam logic [7:0] LABEL_OBST_A = 8'd2;
	localparam logic [7:0] LABEL_OBST_B = 8'd4;
	localparam logic [7:0] LABEL_OBST_C = 8'd6;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

	typedef struct packed {
		logic                                valid;
		logic [63:0]                         tag;
		logic [POLARITIES-1:0][SUM_W-1:0]    sum_x;
		logic [POLARITIES-1:0][SUM_W-1:0]    sum_y;
		logic [POLARITIES-1:0][CNT_W-1:0]    cnt;
	} lvc_row_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
	} lvc_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SUM_W-1:0]  quotient;
		logic [DIVS_W-1:0] remainder;
	} lvc_div_rsp_t;

endpackage

// File: rtl/core/lvc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeled voxel centroid grid channels
// Valid/ready channels for point words and centroid words.
// ----------------------------------------------------------------------------
interface lvc_point_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [7:0]  class_label;
	logic [9:0]  slot_index;

	modport source (output valid, kind, pos_x, pos_y, pos_z, class_label, slot_index,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, pos_z, class_label, slot_index,
		output ready);
endinterface

interface lvc_centroid_if;
	logic        valid;
	logic        ready;
	logic [31:0] centroid_x;
	logic [31:0] centroid_y;
	logic        polarity;
	logic        last_of_slot;
	logic [15:0] dropped_count;

	modport source (output valid, centroid_x, centroid_y, polarity, last_of_slot,
		dropped_count, input ready);
	modport sink (input valid, centroid_x, centroid_y, polarity, last_of_slot,
		dropped_count, output ready);
endinterface

// File: rtl/core/labeled_voxel_centroid_grid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeled voxel centroid grid core
// Voxel-grid centroid accumulator with a hashed cell table.
// ----------------------------------------------------------------------------
// Point words enter on the points channel. A kind 0 word with a road or
// obstacle label is transformed, binned to a cell and added to that cell's
// hash table entry; it gives no centroid word. A kind 1 word reads and clears
// one table slot and sends zero, one or two centroid words on the centroids
// channel, road first, the final one marked by last_of_slot.
// One shared 33 by 33 multiplier and one bit-serial divider do all the work
// under a sequencer, and one word is handled at a time. A point probes up to
// PROBE_LIMIT slots, is dropped and counted if none fits, and is dropped
// uncounted if its cell is out of range. The home slot is the low bits of
// the hash, so TABLE_SLOTS must be a power of two; the core does not check.
// A drain reads the slot, then per centroid selects, divides x and y and
// outputs; an empty road half adds a select step. Other labels are ignored.
// After reset the table is swept clear, one slot a cycle; points.ready stays
// low meanwhile. Registers must be written on the APB port only while the
// core is idle; the core does not enforce it. A centroid word waits in the
// output register while the receiver stalls, and a further word is held.
// ----------------------------------------------------------------------------
module labeled_voxel_centroid_grid_core
	import lvc_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int unsigned PROBE_LIMIT = DEF_PROBE_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	lvc_point_if.sink          points,
	lvc_centroid_if.source     centroids
);

	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
	localparam int unsigned PRB_W = $clog2(PROBE_LIMIT) + 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TX0, ST_TX1, ST_TX2, ST_TY0, ST_TY1, ST_TY2,
		ST_CX0, ST_CX1, ST_CY0, ST_CY1, ST_H0, ST_H1, ST_H2, ST_H3, ST_H4,
		ST_PRD, ST_PCHK, ST_DRD, ST_DCHK, ST_DSEL, ST_DDX, ST_DDY, ST_DOUT
	} state_t;

	state_t state_q;

	logic [47:0] rot_x_q;
	logic [47:0] rot_y_q;
	logic [31:0] trans_x_q;
	logic [31:0] trans_y_q;
	logic [31:0] inv_q;

	logic [31:0] px_q, py_q, pz_q;
	logic        pol_q;
	logic [9:0]  didx_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;
	logic signed [71:0] acc_q;
	logic signed [71:0] acc_sum;
	logic signed [37:0] tx_q, ty_q;
	logic signed [37:0] t_new;
	logic signed [37:0] t_sel;
	logic [39:0]        cell_idx;
	logic [31:0]        ix_q;
	logic [31:0]        iy_q;
	logic               oor_q;
	logic [31:0]        h_q;
	logic [31:0]        h_next;
	logic [63:0]        key;

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_next;
	logic [PRB_W-1:0]  probe_q;
	logic [DROP_W-1:0] drop_q;

	logic              clr_busy_q;
	logic [SLOT_W-1:0] clr_q;

	lvc_row_t          rd_row;
	lvc_row_t          row_q;
	lvc_row_t          wr_row;
	lvc_row_t          upd_row;
	logic              we;
	logic [SLOT_W-1:0] waddr;
	logic              re;
	logic [SLOT_W-1:0] raddr;

	lvc_div_req_t div_req;
	lvc_div_rsp_t div_rsp;
	logic         sum_neg;
	logic [31:0]  qx_q;
	logic [31:0]  qy_q;
	logic [31:0]  q_signed;

	logic        out_valid_q;
	logic [31:0] out_x_q, out_y_q;
	logic        out_pol_q, out_last_q;
	logic [15:0] out_drop_q;

	logic        hit, claim;
	logic [31:0] idx_ext;
	logic        idx_ok;
	logic        label_road, label_obst;
	logic signed [SUM_W-1:0] sat_x, sat_y;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[5:3])
			REG_ROT_ROW_X: prdata = {16'd0, rot_x_q};
			REG_ROT_ROW_Y: prdata = {16'd0, rot_y_q};
			REG_TRANS_X: prdata = {32'd0, trans_x_q};
			REG_TRANS_Y: prdata = {32'd0, trans_y_q};
			REG_INV_VOXEL: prdata = {32'd0, inv_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= ROT_X_RESET;
			rot_y_q <= ROT_Y_RESET;
			trans_x_q <= '0;
			trans_y_q <= '0;
			inv_q <= INV_VOXEL_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[5:3])
				REG_ROT_ROW_X: rot_x_q <= pwdata[47:0];
				REG_ROT_ROW_Y: rot_y_q <= pwdata[47:0];
				REG_TRANS_X: trans_x_q <= pwdata[31:0];
				REG_TRANS_Y: trans_y_q <= pwdata[31:0];
				REG_INV_VOXEL: inv_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	assign label_road = (points.class_label == LABEL_ROAD_A) ||
		(points.class_label == LABEL_ROAD_B);
	assign label_obst = (points.class_label == LABEL_OBST_A) ||
		(points.class_label == LABEL_OBST_B) || (points.class_label == LABEL_OBST_C);

	assign points.ready = (state_q == ST_IDLE) && !clr_busy_q;

	assign idx_ext = {22'd0, didx_q};
	assign idx_ok = idx_ext < TABLE_SLOTS;

	assign acc_sum = acc_q + 72'(prod_q);
	assign t_new = 38'(acc_sum[51:14]);
	assign cell_idx = acc_sum[71:32];
	assign key = {ix_q, iy_q};
	assign slot_next = (32'(slot_q) == TABLE_SLOTS - 1) ? '0 : slot_q + 1'b1;
	assign t_sel = (state_q == ST_CX0 || state_q == ST_CX1) ? tx_q : ty_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		h_next = h_q + prod_q[31:0];
		unique case (state_q)
			ST_TX0: begin mul_a = 33'(signed'(rot_x_q[15:0])); mul_b = 33'(signed'(px_q)); end
			ST_TX1: begin mul_a = 33'(signed'(rot_x_q[31:16])); mul_b = 33'(signed'(py_q)); end
			ST_TX2: begin mul_a = 33'(signed'(rot_x_q[47:32])); mul_b = 33'(signed'(pz_q)); end
			ST_TY0: begin mul_a = 33'(signed'(rot_y_q[15:0])); mul_b = 33'(signed'(px_q)); end
			ST_TY1: begin mul_a = 33'(signed'(rot_y_q[31:16])); mul_b = 33'(signed'(py_q)); end
			ST_TY2: begin mul_a = 33'(signed'(rot_y_q[47:32])); mul_b = 33'(signed'(pz_q)); end
			ST_CX0, ST_CY0: begin
				mul_a = 33'(signed'(t_sel[37:16]));
				mul_b = {1'b0, inv_q};
			end
			ST_CX1, ST_CY1: begin
				mul_a = {17'd0, t_sel[15:0]};
				mul_b = {1'b0, inv_q};
			end
			ST_H1: begin mul_a = {1'b0, iy_q}; mul_b = {1'b0, HASH_MUL_LO}; end
			ST_H2: begin mul_a = {1'b0, ix_q}; mul_b = {1'b0, HASH_MUL_LO}; end
			ST_H3: begin mul_a = {1'b0, iy_q}; mul_b = {1'b0, HASH_MUL_HI}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign hit = rd_row.valid && (rd_row.tag == key);
	assign claim = !rd_row.valid;

	assign sat_x = ($signed(tx_q) > 38'sd2147483647) ? SUM_W'(32'sh7FFFFFFF) :
		($signed(tx_q) < -38'sd2147483648) ? SUM_W'(-64'sd2147483648) : SUM_W'(tx_q);
	assign sat_y = ($signed(ty_q) > 38'sd2147483647) ? SUM_W'(32'sh7FFFFFFF) :
		($signed(ty_q) < -38'sd2147483648) ? SUM_W'(-64'sd2147483648) : SUM_W'(ty_q);

	always_comb begin
		upd_row = rd_row;
		upd_row.valid = 1'b1;
		upd_row.tag = key;
		if (rd_row.cnt[pol_q] != COUNT_MAX) begin
			upd_row.sum_x[pol_q] = rd_row.sum_x[pol_q] + sat_x;
			upd_row.sum_y[pol_q] = rd_row.sum_y[pol_q] + sat_y;
			upd_row.cnt[pol_q] = rd_row.cnt[pol_q] + 1'b1;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wr_row = '0;
		re = 1'b0;
		raddr = slot_q;
		if (clr_busy_q) begin
			we = 1'b1;
			waddr = clr_q;
		end else if (state_q == ST_PCHK && (hit || claim)) begin
			we = 1'b1;
			wr_row = upd_row;
		end else if (state_q == ST_DCHK && rd_row.valid) begin
			we = 1'b1;
			waddr = idx_ext[SLOT_W-1:0];
		end
		if (state_q == ST_PRD) begin
			re = 1'b1;
		end else if (state_q == ST_DRD) begin
			re = 1'b1;
			raddr = idx_ext[SLOT_W-1:0];
		end
	end

	lvc_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wr_row),
		.re(re),
		.raddr(raddr),
		.rdata(rd_row)
	);

	assign sum_neg = (state_q == ST_DSEL) ? row_q.sum_x[pol_q][SUM_W-1] :
		row_q.sum_y[pol_q][SUM_W-1];

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = DIVS_W'(row_q.cnt[pol_q]);
		if (state_q == ST_DSEL && row_q.cnt[pol_q] != '0) begin
			div_req.start = 1'b1;
			div_req.dividend = sum_neg ? SUM_W'(-row_q.sum_x[pol_q]) : row_q.sum_x[pol_q];
		end else if (state_q == ST_DDX && div_rsp.done) begin
			div_req.start = 1'b1;
			div_req.dividend = sum_neg ? SUM_W'(-row_q.sum_y[pol_q]) : row_q.sum_y[pol_q];
		end
	end

	lvc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign q_signed = (state_q == ST_DDX ? row_q.sum_x[pol_q][SUM_W-1] :
		row_q.sum_y[pol_q][SUM_W-1]) ? 32'(-div_rsp.quotient) : div_rsp.quotient[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_q <= '0;
			drop_q <= '0;
			out_valid_q <= 1'b0;
			probe_q <= '0;
			pol_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (32'(clr_q) == TABLE_SLOTS - 1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (state_q == ST_DOUT && (!out_valid_q || centroids.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && centroids.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (points.valid && points.ready) begin
						px_q <= points.pos_x;
						py_q <= points.pos_y;
						pz_q <= points.pos_z;
						didx_q <= points.slot_index;
						if (points.kind) begin
							state_q <= ST_DRD;
						end else if (label_road || label_obst) begin
							pol_q <= label_obst;
							state_q <= ST_TX0;
						end
					end
				end
				ST_TX0: state_q <= ST_TX1;
				ST_TX1: begin acc_q <= 72'(prod_q); state_q <= ST_TX2; end
				ST_TX2: begin acc_q <= acc_sum; state_q <= ST_TY0; end
				ST_TY0: begin
					tx_q <= t_new + 38'(signed'(trans_x_q));
					state_q <= ST_TY1;
				end
				ST_TY1: begin acc_q <= 72'(prod_q); state_q <= ST_TY2; end
				ST_TY2: begin acc_q <= acc_sum; state_q <= ST_CX0; end
				ST_CX0: begin
					ty_q <= t_new + 38'(signed'(trans_y_q));
					state_q <= ST_CX1;
				end
				ST_CX1: begin acc_q <= 72'(prod_q) <<< 16; state_q <= ST_CY0; end
				ST_CY0: begin
					ix_q <= cell_idx[31:0];
					oor_q <= cell_idx[39:31] != {9{cell_idx[31]}};
					state_q <= ST_CY1;
				end
				ST_CY1: begin acc_q <= 72'(prod_q) <<< 16; state_q <= ST_H0; end
				ST_H0: begin
					iy_q <= cell_idx[31:0];
					if (oor_q || (cell_idx[39:31] != {9{cell_idx[31]}})) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_H1;
					end
				end
				ST_H1: state_q <= ST_H2;
				ST_H2: begin h_q <= prod_q[63:32]; state_q <= ST_H3; end
				ST_H3: begin h_q <= h_next; state_q <= ST_H4; end
				ST_H4: begin
					slot_q <= h_next[SLOT_W-1:0];
					probe_q <= '0;
					state_q <= ST_PRD;
				end
				ST_PRD: state_q <= ST_PCHK;
				ST_PCHK: begin
					if (hit || claim) begin
						state_q <= ST_IDLE;
					end else if (probe_q == PRB_W'(PROBE_LIMIT - 1)) begin
						if (drop_q != DROP_MAX) begin
							drop_q <= drop_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
						slot_q <= slot_next;
						state_q <= ST_PRD;
					end
				end
				ST_DRD: state_q <= idx_ok ? ST_DCHK : ST_IDLE;
				ST_DCHK: begin
					row_q <= rd_row;
					pol_q <= 1'b0;
					state_q <= rd_row.valid ? ST_DSEL : ST_IDLE;
				end
				ST_DSEL: begin
					if (row_q.cnt[pol_q] != '0) begin
						state_q <= ST_DDX;
					end else if (pol_q) begin
						state_q <= ST_IDLE;
					end else begin
						pol_q <= 1'b1;
					end
				end
				ST_DDX: begin
					if (div_rsp.done) begin
						qx_q <= q_signed;
						state_q <= ST_DDY;
					end
				end
				ST_DDY: begin
					if (div_rsp.done) begin
						qy_q <= q_signed;
						state_q <= ST_DOUT;
					end
				end
				ST_DOUT: begin
					if (!out_valid_q || centroids.ready) begin
						out_x_q <= qx_q;
						out_y_q <= qy_q;
						out_pol_q <= pol_q;
						out_last_q <= pol_q || (row_q.cnt[1] == '0);
						out_drop_q <= drop_q;
						if (pol_q || (row_q.cnt[1] == '0)) begin
							state_q <= ST_IDLE;
						end else begin
							pol_q <= 1'b1;
							state_q <= ST_DSEL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign centroids.valid = out_valid_q;
	assign centroids.centroid_x = out_x_q;
	assign centroids.centroid_y = out_y_q;
	assign centroids.polarity = out_pol_q;
	assign centroids.last_of_slot = out_last_q;
	assign centroids.dropped_count = out_drop_q;

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (drop_q >= $past(drop_q)))
		else $error("drop counter decreased");

	a_no_point_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !points.ready)
		else $error("point accepted during table clear");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !centroids.ready) |=> $stable(out_x_q) && $stable(out_y_q))
		else $error("pending centroid word overwritten");

endmodule

// File: rtl/core/lvc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeled voxel centroid grid divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lvc_div
	import lvc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lvc_div_req_t req,
	output lvc_div_rsp_t rsp
);

	localparam int unsigned STEP_W = $clog2(SUM_W + 1);

	logic [DIVS_W:0]   rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   shifted;
	logic [DIVS_W+1:0] trial;

	assign shifted = {rem_q[DIVS_W-1:0], quo_q[SUM_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DIVS_W+1]) begin
				rem_q <= trial[DIVS_W:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q[DIVS_W-1:0];

endmodule

// File: rtl/core/lvc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeled voxel centroid grid table
// Cell table memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lvc_table
	import lvc_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  lvc_row_t          wdata,
	input  logic              re,
	input  logic [SLOT_W-1:0] raddr,
	output lvc_row_t          rdata
);

	lvc_row_t mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
